@@ rtl/core/two_class_priority_queue_top_macros.svh @@
// assertion macros for the two-class priority queue
`ifndef TWO_CLASS_PRIORITY_QUEUE_TOP_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TCPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tcpq_pkg.sv @@
// shared types and constants for the two-class priority queue
package tcpq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_SERVE    = 2'd1,
        CMD_WITHDRAW = 2'd2,
        CMD_QUERY    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_DUP      = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
        logic pref_new;
    } ctrl_t;

endpackage

@@ rtl/core/tcpq_cmd_if.sv @@
// command channel: valid/ready handshake with command payload
interface tcpq_cmd_if
    import tcpq_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic signed [ID_BITS-1:0] id_in;
    logic                      preferred_in;

    modport source (output valid, output cmd, output id_in, output preferred_in,
                    input ready);
    modport sink   (input valid, input cmd, input id_in, input preferred_in,
                    output ready);
endinterface

@@ rtl/core/tcpq_rsp_if.sv @@
// response channel: valid/ready handshake with result payload
interface tcpq_rsp_if
    import tcpq_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF,
    parameter int DEPTH   = DEPTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [2:0]                   status;
    logic [ID_BITS-2:0]           id_out;
    logic                         preferred_out;
    logic [$clog2(DEPTH+1)-1:0]   occupancy;

    modport source (output valid, output ok, output status, output id_out,
                    output preferred_out, output occupancy, input ready);
    modport sink   (input valid, input ok, input status, input id_out,
                    input preferred_out, input occupancy, output ready);
endinterface

@@ rtl/core/tcpq_prefix.sv @@
// log-depth prefix or over the cell match flags
module tcpq_prefix #(
    parameter int N = 16
) (
    input  logic [N-1:0] match,
    output logic [N-1:0] prefix
);
    localparam int STEPS = (N > 1) ? $clog2(N) : 1;

    always_comb
    begin
        prefix = match;
        for (int s = 0; s < STEPS; s++)
        begin
            prefix = prefix | (prefix << (1 << s));
        end
    end
endmodule

@@ rtl/core/tcpq_cell.sv @@
// one queue slot: holds an id and a priority bit, shifts with its neighbors
module tcpq_cell
    import tcpq_pkg::*;
#(
    parameter int KW = 15
) (
    input  logic          clk,
    input  ctrl_t         ctrl,
    input  logic          valid,
    input  logic [KW-1:0] key,
    input  logic          left_ge,
    input  logic [KW-1:0] left_id,
    input  logic          left_pref,
    input  logic [KW-1:0] right_id,
    input  logic          right_pref,
    input  logic          rem_take,
    output logic [KW-1:0] id,
    output logic          pref,
    output logic          match,
    output logic          ins_ge
);
    logic [KW-1:0] id_reg, id_next;
    logic          pref_reg, pref_next;

    // at or behind the insertion point
    assign ins_ge = ctrl.pref_new ? !(valid && pref_reg) : !valid;
    assign match  = valid && (id_reg == key);
    assign id     = id_reg;
    assign pref   = pref_reg;

    always_comb
    begin
        id_next   = id_reg;
        pref_next = pref_reg;
        if (ctrl.ins)
        begin
            if (ins_ge && !left_ge)
            begin
                id_next   = key;
                pref_next = ctrl.pref_new;
            end
            else if (ins_ge)
            begin
                id_next   = left_id;
                pref_next = left_pref;
            end
        end
        else if (ctrl.rem && rem_take)
        begin
            id_next   = right_id;
            pref_next = right_pref;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        pref_reg <= pref_next;
    end
endmodule

@@ rtl/core/two_class_priority_queue_top.sv @@
// channel | dir | payload                                        | transfer
// req     | in  | cmd, id_in, preferred_in                       | valid && ready
// rsp     | out | ok, status, id_out, preferred_out, occupancy   | valid && ready
//
// one command per cycle while req.ready is high; its result is registered and shows the cycle after transfer
// the row of cells compares all ids and shifts in the same cycle as the transfer
// req.ready is high while the result register is empty or being taken
// reset clears the occupancy count and the result valid flag; slot contents need no clearing
`include "two_class_priority_queue_top_macros.svh"
module two_class_priority_queue_top
    import tcpq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    tcpq_cmd_if.sink       req,
    tcpq_rsp_if.source     rsp
);
    localparam int KW    = ID_BITS - 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [KW-1:0]    id_out_reg, id_out_next;
    logic             pref_out_reg, pref_out_next;

    logic [DEPTH-1:0] valid_vec, match_vec, ge_vec, pref_vec, rem_prefix, rem_take;
    logic [KW-1:0]    cell_id [DEPTH];
    logic [KW-1:0]    key;
    logic             neg, found, full, empty, in_xfer, do_ins, do_rem, serve;
    ctrl_t            ctrl;
    cmd_t             cmd;

    assign cmd     = cmd_t'(req.cmd);
    assign key     = req.id_in[KW-1:0];
    assign neg     = req.id_in[ID_BITS-1];
    assign in_xfer = req.valid && req.ready;
    assign found   = (|match_vec) && !neg;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    assign ctrl.ins      = do_ins;
    assign ctrl.rem      = do_rem;
    assign ctrl.pref_new = req.preferred_in;

    tcpq_prefix #(.N(DEPTH)) u_prefix (
        .match  (match_vec),
        .prefix (rem_prefix)
    );

    // serve drops the head, withdraw drops the matching slot and all behind it shift
    assign rem_take = serve ? {DEPTH{1'b1}} : rem_prefix;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic          l_ge, l_pref, r_pref;
        logic [KW-1:0] l_id, r_id;

        assign valid_vec[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign l_ge   = 1'b0;
            assign l_id   = '0;
            assign l_pref = 1'b0;
        end
        else
        begin : g_mid
            assign l_ge   = ge_vec[i-1];
            assign l_id   = cell_id[i-1];
            assign l_pref = pref_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_id   = '0;
            assign r_pref = 1'b0;
        end
        else
        begin : g_inner
            assign r_id   = cell_id[i+1];
            assign r_pref = pref_vec[i+1];
        end

        tcpq_cell #(.KW(KW)) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid      (valid_vec[i]),
            .key        (key),
            .left_ge    (l_ge),
            .left_id    (l_id),
            .left_pref  (l_pref),
            .right_id   (r_id),
            .right_pref (r_pref),
            .rem_take   (rem_take[i]),
            .id         (cell_id[i]),
            .pref       (pref_vec[i]),
            .match      (match_vec[i]),
            .ins_ge     (ge_vec[i])
        );
    end

    always_comb
    begin
        do_ins        = 1'b0;
        do_rem        = 1'b0;
        serve         = 1'b0;
        status_next   = ST_OK;
        id_out_next   = '0;
        pref_out_next = 1'b0;
        case (cmd)
            CMD_INSERT:
            begin
                if (neg)
                    status_next = ST_INVALID;
                else if (found)
                    status_next = ST_DUP;
                else if (full)
                    status_next = ST_FULL;
                else
                    do_ins = in_xfer;
            end
            CMD_SERVE:
            begin
                serve = 1'b1;
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    id_out_next   = cell_id[0];
                    pref_out_next = pref_vec[0];
                    do_rem        = in_xfer;
                end
            end
            CMD_WITHDRAW:
            begin
                if (!found)
                    status_next = ST_NOTFOUND;
                else
                    do_rem = in_xfer;
            end
            CMD_QUERY:
            begin
                if (!found)
                    status_next = ST_NOTFOUND;
                else
                    pref_out_next = |(match_vec & pref_vec);
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + 1'b1;
        else if (do_rem)
            count_next = count_reg - 1'b1;
    end

    always_comb
    begin
        if (in_xfer)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            status_reg   <= status_next;
            id_out_reg   <= id_out_next;
            pref_out_reg <= pref_out_next;
        end
    end

    assign req.ready         = !out_valid_reg || rsp.ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.ok            = (status_reg == ST_OK);
    assign rsp.status        = status_reg;
    assign rsp.id_out        = id_out_reg;
    assign rsp.preferred_out = pref_out_reg;
    assign rsp.occupancy     = count_reg;

    `TCPQ_ASSERT_NOW(a_ins_not_full, clk, rst_n, do_ins, !valid_vec[DEPTH-1], "insert into full queue")
    `TCPQ_ASSERT_NOW(a_rem_not_empty, clk, rst_n, do_rem, valid_vec[0], "removal from empty queue")
    `TCPQ_ASSERT_NEXT(a_ins_count, clk, rst_n, do_ins, count_reg == $past(count_reg) + 1'b1, "insert count step")
    `TCPQ_ASSERT_NOW(a_occ_match, clk, rst_n, rsp.valid, rsp.occupancy == count_reg, "occupancy out of step")
endmodule

@@ bench/tb_two_class_priority_queue_top.sv @@
// self-checking testbench for the two-class priority queue top level
module tb_two_class_priority_queue_top;
    import tcpq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;
    localparam int ID_W   = ID_BITS_DEF;
    localparam int OCC_W  = $clog2(QDEPTH + 1);

    typedef struct {
        logic             ok;
        status_t          status;
        logic [ID_W-2:0]  id_out;
        logic             preferred_out;
        logic [OCC_W-1:0] occupancy;
    } queue_result_t;

    logic clk;
    logic rst_n;

    tcpq_cmd_if #(.ID_BITS(ID_W)) req_ch ();
    tcpq_rsp_if #(.ID_BITS(ID_W), .DEPTH(QDEPTH)) rsp_ch ();

    two_class_priority_queue_top #(
        .DEPTH   (QDEPTH),
        .ID_BITS (ID_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the queue contents, head at slot 0
    logic [ID_W-2:0] model_ids [QDEPTH];
    logic            model_pref [QDEPTH];
    int              model_count = 0;

    queue_result_t   pending_results[$];
    queue_result_t   want;
    int              fail_count   = 0;
    int              tx_idle_pct  = 0;
    int              rx_idle_pct  = 0;
    int              rx_hold_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int find_slot(input logic [ID_W-2:0] key);
        for (int i = 0; i < model_count; i++)
            if (model_ids[i] == key)
                return i;
        return QDEPTH;
    endfunction

    function automatic void drop_slot(input int pos);
        for (int i = pos; i + 1 < model_count; i++)
        begin
            model_ids[i]  = model_ids[i + 1];
            model_pref[i] = model_pref[i + 1];
        end
        model_count--;
    endfunction

    // updates the shadow queue and returns the result the block must give
    function automatic queue_result_t apply_command(input cmd_t c,
                                                    input logic signed [ID_W-1:0] id,
                                                    input logic pref);
        queue_result_t   r;
        logic [ID_W-2:0] key;
        logic            neg;
        int              pos;
        r.status        = ST_OK;
        r.id_out        = '0;
        r.preferred_out = 1'b0;
        key = id[ID_W-2:0];
        neg = id[ID_W-1];
        case (c)
            CMD_INSERT:
            begin
                if (neg)
                    r.status = ST_INVALID;
                else if (find_slot(key) != QDEPTH)
                    r.status = ST_DUP;
                else if (model_count >= QDEPTH)
                    r.status = ST_FULL;
                else
                begin
                    pos = model_count;
                    if (pref)
                    begin
                        // preferred entries go right behind the last preferred one
                        pos = 0;
                        while (pos < model_count && model_pref[pos])
                            pos++;
                    end
                    for (int i = model_count; i > pos; i--)
                    begin
                        model_ids[i]  = model_ids[i - 1];
                        model_pref[i] = model_pref[i - 1];
                    end
                    model_ids[pos]  = key;
                    model_pref[pos] = pref;
                    model_count++;
                end
            end
            CMD_SERVE:
            begin
                if (model_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.id_out        = model_ids[0];
                    r.preferred_out = model_pref[0];
                    drop_slot(0);
                end
            end
            default:
            begin
                pos = neg ? QDEPTH : find_slot(key);
                if (pos == QDEPTH)
                    r.status = ST_NOTFOUND;
                else if (c == CMD_WITHDRAW)
                    drop_slot(pos);
                else
                    r.preferred_out = model_pref[pos];
            end
        endcase
        r.ok        = (r.status == ST_OK);
        r.occupancy = OCC_W'(model_count);
        return r;
    endfunction

    // mostly a small pool so duplicates and hits are common, plus stored ids, random full-range ids and extremes
    function automatic logic signed [ID_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return ID_W'($urandom_range(23));
        if (roll < 80 && model_count > 0)
            return {1'b0, model_ids[$urandom_range(model_count - 1)]};
        if (roll < 92)
            return ID_W'($urandom_range(65535));
        case ($urandom_range(3))
            0:       return '0;
            1:       return {1'b0, {(ID_W-1){1'b1}}};
            2:       return '1;
            default: return {1'b1, {(ID_W-1){1'b0}}};
        endcase
    endfunction

    // valid stays high after a transfer so back-to-back commands need no idle gap
    task automatic send_cmd(input cmd_t c, input logic signed [ID_W-1:0] id,
                            input logic pref);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= c;
        req_ch.id_in        <= id;
        req_ch.preferred_in <= pref;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(apply_command(c, id, pref));
    endtask

    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_commands();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_cmd(CMD_SERVE, ID_W'(0), 1'b0);
        send_cmd(CMD_WITHDRAW, ID_W'(3), 1'b0);
        send_cmd(CMD_QUERY, ID_W'(3), 1'b1);
        send_cmd(CMD_INSERT, {1'b1, {(ID_W-1){1'b0}}}, 1'b1);
        send_cmd(CMD_INSERT, ID_W'(-1), 1'b0);
        send_cmd(CMD_INSERT, ID_W'(0), 1'b0);
        send_cmd(CMD_INSERT, {1'b0, {(ID_W-1){1'b1}}}, 1'b1);
        send_cmd(CMD_INSERT, ID_W'(0), 1'b1);
        send_cmd(CMD_INSERT, ID_W'(5), 1'b1);
        send_cmd(CMD_INSERT, ID_W'(7), 1'b0);
        send_cmd(CMD_QUERY, ID_W'(0), 1'b0);
        send_cmd(CMD_QUERY, {1'b0, {(ID_W-1){1'b1}}}, 1'b0);
        send_cmd(CMD_QUERY, ID_W'(-1), 1'b0);
        send_cmd(CMD_WITHDRAW, ID_W'(-1), 1'b0);
        send_cmd(CMD_WITHDRAW, ID_W'(9), 1'b0);
        send_cmd(CMD_WITHDRAW, ID_W'(5), 1'b0);
        send_cmd(CMD_SERVE, ID_W'(0), 1'b0);
        send_cmd(CMD_SERVE, ID_W'(0), 1'b0);
        send_cmd(CMD_SERVE, ID_W'(0), 1'b0);
        send_cmd(CMD_SERVE, ID_W'(0), 1'b0);
        wait_all_results();
    endtask

    task automatic test_full_queue();
        tx_idle_pct = 0;
        rx_idle_pct = 30;
        for (int i = 0; i < QDEPTH; i++)
            send_cmd(CMD_INSERT, ID_W'(100 + i), (i % 3) == 0);
        send_cmd(CMD_INSERT, ID_W'(200), 1'b1);
        send_cmd(CMD_INSERT, ID_W'(100), 1'b0);
        send_cmd(CMD_INSERT, ID_W'(-5), 1'b0);
        send_cmd(CMD_QUERY, ID_W'(115), 1'b0);
        for (int i = 0; i <= QDEPTH; i++)
            send_cmd(CMD_SERVE, ID_W'(0), 1'b0);
        wait_all_results();
    endtask

    // receiver stalls long enough that the result register fills and req.ready drops
    task automatic test_receiver_hold();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 300;
        for (int i = 0; i < 24; i++)
            send_cmd(cmd_t'((i % 3) == 2 ? CMD_SERVE : CMD_INSERT), ID_W'(300 + i), i[0]);
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int   roll;
        logic fill_bias;
        cmd_t c;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        fill_bias   = 1'b1;
        for (int n = 0; n < n_items; n++)
        begin
            // bursts lean toward filling or draining so both full and empty get hit
            if (n % 40 == 0)
                fill_bias = 1'($urandom_range(1));
            roll = $urandom_range(99);
            if (fill_bias)
                c = cmd_t'(roll < 65 ? CMD_INSERT : roll < 75 ? CMD_SERVE :
                           roll < 87 ? CMD_WITHDRAW : CMD_QUERY);
            else
                c = cmd_t'(roll < 25 ? CMD_INSERT : roll < 60 ? CMD_SERVE :
                           roll < 80 ? CMD_WITHDRAW : CMD_QUERY);
            send_cmd(c, pick_id(), 1'($urandom_range(1)));
        end
        wait_all_results();
    endtask

    // receiver side: random stalls, or a counted hold-off when one is requested
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.ok !== want.ok)
                begin
                    $error("ok: expected %0d actual %0d", want.ok, rsp_ch.ok);
                    fail_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.id_out !== want.id_out)
                begin
                    $error("id_out: expected %0d actual %0d", want.id_out, rsp_ch.id_out);
                    fail_count++;
                end
                if (rsp_ch.preferred_out !== want.preferred_out)
                begin
                    $error("preferred_out: expected %0d actual %0d",
                           want.preferred_out, rsp_ch.preferred_out);
                    fail_count++;
                end
                if (rsp_ch.occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d actual %0d",
                           want.occupancy, rsp_ch.occupancy);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_INSERT;
        req_ch.id_in        = '0;
        req_ch.preferred_in = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_commands();
        test_full_queue();
        test_receiver_hold();
        test_random_traffic(240, 23, 76);
        test_random_traffic(240, 76, 23);
        test_random_traffic(240, 0, 0);

        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
